// ===== design/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; imported by every module of the block.
package wbps_pkg;

    localparam int REG_BYTES = 16;
    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 48;
    localparam int LEN_REG_W = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_WILDCARD_MASK  = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_BYTES*DATA_W-1:0] pattern;
        logic [REG_BYTES-1:0]        wild;
        logic [LEN_REG_W-1:0]        length;
    } scan_cfg_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } match_t;

endpackage

// ===== design/wbps_window.sv =====
// Input stage: shift window of recent bytes, region fill count and address.
// Depends on wbps_pkg.
module wbps_window
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_byte,
    input  logic [ADDR_W-1:0] byte_address,
    input  logic              region_start,
    input  logic              out_free,
    output logic              stage_valid,
    output logic [DATA_W-1:0] window [MAX_PATTERN_BYTES],
    output logic [FILL_W-1:0] fill,
    output logic [ADDR_W-1:0] addr
);

    logic              valid_reg;
    logic              valid_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_base;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] window_reg  [MAX_PATTERN_BYTES];
    logic [DATA_W-1:0] window_next [MAX_PATTERN_BYTES];
    logic              accept;

    assign in_ready = !valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // restart the count at a region start, saturate at the window depth
        fill_base = region_start ? '0 : fill_reg;
        if (fill_base < FILL_W'(MAX_PATTERN_BYTES))
        begin
            fill_next = fill_base + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_base;
        end

        window_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            window_next[k] = window_reg[k-1];
        end

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= byte_address;
            window_reg <= window_next;
        end
    end

    assign stage_valid = valid_reg;
    assign window      = window_reg;
    assign fill        = fill_reg;
    assign addr        = addr_reg;

endmodule

// ===== design/wbps_match.sv =====
// Parallel wildcard compare of the window against the signature.
// Depends on wbps_pkg.
module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1)
)
(
    input  scan_cfg_t         cfg,
    input  logic [DATA_W-1:0] window [MAX_PATTERN_BYTES],
    input  logic [FILL_W-1:0] fill,
    input  logic [ADDR_W-1:0] addr,
    output match_t            result
);

    localparam int LEN_W = (FILL_W > LEN_REG_W) ? FILL_W : LEN_REG_W;
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [LEN_W-1:0]             len_raw;
    logic [LEN_W-1:0]             len;
    logic [MAX_PATTERN_BYTES-1:0] lane_ok;

    assign len_raw = LEN_W'(cfg.length);
    assign len     = (len_raw > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
                                                            : len_raw;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_lane
        logic [DATA_W-1:0] pat_byte;
        logic              wild;
        logic [LEN_W-1:0]  idx_full;

        // signature bytes past the register file compare as zero, never wild
        if (k < REG_BYTES)
        begin : g_cfg
            assign pat_byte = cfg.pattern[k*DATA_W +: DATA_W];
            assign wild     = cfg.wild[k];
        end
        else
        begin : g_zero
            assign pat_byte = '0;
            assign wild     = 1'b0;
        end

        // signature byte k lines up with the byte len-1-k places back
        assign idx_full   = len - LEN_W'(1) - LEN_W'(k);
        assign lane_ok[k] = (LEN_W'(k) >= len) || wild
                            || (window[idx_full[IDX_W-1:0]] == pat_byte);
    end

    assign result.hit  = (len != '0) && (LEN_W'(fill) >= len) && (&lane_ok);
    assign result.addr = addr - ADDR_W'(len) + ADDR_W'(1);

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// Wildcard byte pattern scanner, top level: config registers, output register.
// Depends on wbps_pkg, wbps_window and wbps_match.
// An input byte passes the window register, then the output register, before its match transfer.
// Throughput: one byte per cycle while the output register is not stalled, set by the single window-register stage.
// Reset clears the fill count and both valid flags; the config registers return
// to an all-zero pattern and mask with a pattern length of one.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte[7:0], byte_address[55:8]
    input  logic                   s_axis_tuser,   // region_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // match_address[47:0]
);

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

    scan_cfg_t         cfg_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_free;
    logic              stage_valid;
    logic [DATA_W-1:0] window [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] fill;
    logic [ADDR_W-1:0] stage_addr;
    match_t            result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern <= '0;
            cfg_reg.wild    <= '0;
            cfg_reg.length  <= LEN_REG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LOW:    cfg_reg.pattern[CFG_W-1:0] <= cfg_data;
                CFG_PATTERN_HIGH:   cfg_reg.pattern[2*CFG_W-1:CFG_W] <= cfg_data;
                CFG_WILDCARD_MASK:  cfg_reg.wild   <= cfg_data[REG_BYTES-1:0];
                CFG_PATTERN_LENGTH: cfg_reg.length <= cfg_data[LEN_REG_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    wbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .data_byte    (s_axis_tdata[DATA_W-1:0]),
        .byte_address (s_axis_tdata[DATA_W +: ADDR_W]),
        .region_start (s_axis_tuser),
        .out_free     (out_free),
        .stage_valid  (stage_valid),
        .window       (window),
        .fill         (fill),
        .addr         (stage_addr)
    );

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .cfg    (cfg_reg),
        .window (window),
        .fill   (fill),
        .addr   (stage_addr),
        .result (result)
    );

    // the output register takes a new transfer whenever it is empty or draining
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign out_valid_next = out_free ? (stage_valid && result.hit) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_valid && result.hit)
        begin
            out_addr_reg <= result.addr;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;

endmodule

// ===== design/wbps_checker.sv =====
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner.
module wbps_checker
    import wbps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // hold a stalled result and its address
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer dropped or changed");

    // an empty output register never blocks the input side
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    // a fresh result must trace back to an input transfer through the window and output registers
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a matching input transfer");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
